FILE: hw/rtl/longest_prefix_match_trie_macros.svh
// Assertion macros shared by the RTL that checks itself.
`ifndef LONGEST_PREFIX_MATCH_TRIE_MACROS_SVH
`define LONGEST_PREFIX_MATCH_TRIE_MACROS_SVH

// Same-cycle implication under the block clock and reset.
`define LPM_ASSERT_IMP(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication under the block clock and reset.
`define LPM_ASSERT_NXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/lpm_pkg.sv
`default_nettype none

package lpm_pkg;

    localparam int KEY_BITS       = 128;
    localparam int IPV4_BITS      = 32;
    localparam int NODES_DEF      = 1024;
    localparam int ADDR_BITS_DEF  = 128;
    localparam int ROUTE_BITS_DEF = 16;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Field write enables of the node store.
    typedef struct packed {
        logic skip;
        logic c0;
        logic c1;
        logic route;
    } wr_en_t;

    // Commands to the bit-serial key and skip shifter.
    typedef struct packed {
        logic load_key;
        logic load_skip;
        logic shift_key;
        logic shift_skip;
    } shift_cmd_t;

    // Keeps the top c bits of a left-aligned value and clears the rest.
    function automatic logic [KEY_BITS-1:0] keep_top(input logic [KEY_BITS-1:0] v,
                                                     input logic [7:0] c);
        logic [KEY_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < KEY_BITS; i++) begin
            if (8'(i) < c)
            begin
                r[KEY_BITS-1-i] = v[KEY_BITS-1-i];
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/lpm_mem.sv
`default_nettype none

module lpm_mem #(
    parameter int NODES      = lpm_pkg::NODES_DEF,
    parameter int ROUTE_BITS = lpm_pkg::ROUTE_BITS_DEF,
    parameter int PTR_W      = $clog2(NODES + 1),
    parameter int IDX_W      = $clog2(NODES)
) (
    input  wire logic                          clk,
    input  wire logic                          rd_en,
    input  wire logic [IDX_W-1:0]              rd_addr,
    input  wire logic [IDX_W-1:0]              wr_addr,
    input  wire lpm_pkg::wr_en_t               wr_en,
    input  wire logic [lpm_pkg::KEY_BITS-1:0]  wr_skip,
    input  wire logic [6:0]                    wr_slen,
    input  wire logic [PTR_W-1:0]              wr_c0,
    input  wire logic [PTR_W-1:0]              wr_c1,
    input  wire logic [ROUTE_BITS:0]           wr_route,
    output logic      [lpm_pkg::KEY_BITS-1:0]  rd_skip,
    output logic      [6:0]                    rd_slen,
    output logic      [PTR_W-1:0]              rd_c0,
    output logic      [PTR_W-1:0]              rd_c1,
    output logic      [ROUTE_BITS:0]           rd_route
);

    logic [lpm_pkg::KEY_BITS-1:0] skip_mem  [NODES];
    logic [6:0]                   slen_mem  [NODES];
    logic [PTR_W-1:0]             c0_mem    [NODES];
    logic [PTR_W-1:0]             c1_mem    [NODES];
    logic [ROUTE_BITS:0]          route_mem [NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en.skip)
        begin
            skip_mem[wr_addr] <= wr_skip;
            slen_mem[wr_addr] <= wr_slen;
        end
        if (wr_en.c0)
        begin
            c0_mem[wr_addr] <= wr_c0;
        end
        if (wr_en.c1)
        begin
            c1_mem[wr_addr] <= wr_c1;
        end
        if (wr_en.route)
        begin
            route_mem[wr_addr] <= wr_route;
        end
        if (rd_en)
        begin
            rd_skip  <= skip_mem[rd_addr];
            rd_slen  <= slen_mem[rd_addr];
            rd_c0    <= c0_mem[rd_addr];
            rd_c1    <= c1_mem[rd_addr];
            rd_route <= route_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/lpm_shift.sv
`default_nettype none

// Bit-serial comparator: the key and the node's skip bits each shift left one
// bit a cycle while their shift command is set, so the bits under test are always the top ones.
module lpm_shift (
    input  wire logic                          clk,
    input  wire lpm_pkg::shift_cmd_t           cmd,
    input  wire logic [lpm_pkg::KEY_BITS-1:0]  key_in,
    input  wire logic [lpm_pkg::KEY_BITS-1:0]  skip_in,
    output logic      [lpm_pkg::KEY_BITS-1:0]  key,
    output logic      [lpm_pkg::KEY_BITS-1:0]  skip,
    output logic                               key_bit,
    output logic                               mismatch
);

    logic [lpm_pkg::KEY_BITS-1:0] key_reg;
    logic [lpm_pkg::KEY_BITS-1:0] skip_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= key_in;
        end
        else if (cmd.shift_key)
        begin
            key_reg <= {key_reg[lpm_pkg::KEY_BITS-2:0], 1'b0};
        end
        if (cmd.load_skip)
        begin
            skip_reg <= skip_in;
        end
        else if (cmd.shift_skip)
        begin
            skip_reg <= {skip_reg[lpm_pkg::KEY_BITS-2:0], 1'b0};
        end
    end

    assign key      = key_reg;
    assign skip     = skip_reg;
    assign key_bit  = key_reg[lpm_pkg::KEY_BITS-1];
    assign mismatch = key_reg[lpm_pkg::KEY_BITS-1] ^ skip_reg[lpm_pkg::KEY_BITS-1];

endmodule

`default_nettype wire

FILE: hw/rtl/longest_prefix_match_trie.sv
`default_nettype none

// Longest-prefix-match table as a path-compressed binary trie in a node pool of
// NODES entries. Pulse start while busy is low to issue an insert (command 0) or a
// lookup (command 1); busy stays high until done pulses for exactly one cycle with
// route_out, hit and status, which must be captured in that cycle since the
// receiver cannot stall the block. Skip bits are compared one bit per cycle in a
// shared bit-serial comparator, and each visited node also passes through a
// pointer check, a node read and a branch step. An insert also writes the node
// store for splits and new leaves. There is no clearing pass after reset: the
// trie starts empty.
module longest_prefix_match_trie #(
    parameter int NODES      = lpm_pkg::NODES_DEF,
    parameter int ADDR_BITS  = lpm_pkg::ADDR_BITS_DEF,
    parameter int ROUTE_BITS = lpm_pkg::ROUTE_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        command,
    input  wire logic [63:0] addr_high,
    input  wire logic [63:0] addr_low,
    input  wire logic [7:0]  length,
    input  wire logic [15:0] route_in,
    output logic             done,
    output logic      [15:0] route_out,
    output logic             hit,
    output logic             status
);

    `include "longest_prefix_match_trie_macros.svh"

    localparam int PTR_W = $clog2(NODES + 1);
    localparam int IDX_W = $clog2(NODES);
    localparam int KB    = lpm_pkg::KEY_BITS;
    localparam logic [PTR_W:0] POOL_SIZE = (PTR_W + 1)'(NODES);
    localparam logic [7:0] ADDR_LEN = 8'(ADDR_BITS);
    localparam logic [7:0] IPV4_LEN = 8'(lpm_pkg::IPV4_BITS);

    typedef enum logic [3:0] {
        S_IDLE, S_PTR, S_LOAD, S_CMP, S_SPLIT_INTER, S_SPLIT_NODE,
        S_TAIL, S_TAIL_LEAF, S_LINK, S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [ROUTE_BITS-1:0] route_reg, route_next;
    logic [7:0] pos_reg, pos_next;
    logic [6:0] match_reg, match_next;
    logic [PTR_W-1:0] ptr_reg, ptr_next;
    logic [6:0] slen_reg, slen_next;
    logic [PTR_W-1:0] c0_reg, c0_next, c1_reg, c1_next;
    logic [ROUTE_BITS:0] nroute_reg, nroute_next;
    logic [KB-1:0] orig_skip_reg, orig_skip_next;
    logic [KB-1:0] key_orig_reg, key_orig_next;
    logic [PTR_W-1:0] root_reg, root_next;
    logic [PTR_W-1:0] used_reg, used_next;
    logic slot_root_reg, slot_root_next;
    logic [PTR_W-1:0] parent_reg, parent_next;
    logic parent_bit_reg, parent_bit_next;
    logic after_split_reg, after_split_next;
    logic [PTR_W-1:0] link_reg, link_next;
    logic [ROUTE_BITS:0] best_reg, best_next;
    logic fail_reg, fail_next;
    logic done_reg, done_next;
    logic [15:0] route_out_reg, route_out_next;
    logic hit_reg, hit_next;
    logic status_reg, status_next;

    lpm_pkg::shift_cmd_t sh_cmd;
    logic [KB-1:0] sh_key, sh_skip;
    logic sh_bit, sh_mism;

    logic rd_en;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    lpm_pkg::wr_en_t wr_en;
    logic [KB-1:0] wr_skip, rd_skip;
    logic [6:0] wr_slen, rd_slen;
    logic [PTR_W-1:0] wr_c0, wr_c1, rd_c0, rd_c1;
    logic [ROUTE_BITS:0] wr_route, rd_route;

    logic [31:0] route_in_ext;
    logic [31:0] best_ext;
    logic [PTR_W:0] used_ext;
    logic [1:0] need;
    logic [PTR_W-1:0] used_p1, used_p2;
    logic [6:0] rest_len;
    logic tail_bit;

    lpm_shift u_shift (
        .clk      (clk),
        .cmd      (sh_cmd),
        .key_in   ({addr_high, addr_low}),
        .skip_in  (rd_skip),
        .key      (sh_key),
        .skip     (sh_skip),
        .key_bit  (sh_bit),
        .mismatch (sh_mism)
    );

    lpm_mem #(
        .NODES      (NODES),
        .ROUTE_BITS (ROUTE_BITS),
        .PTR_W      (PTR_W),
        .IDX_W      (IDX_W)
    ) u_mem (
        .clk      (clk),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .wr_en    (wr_en),
        .wr_skip  (wr_skip),
        .wr_slen  (wr_slen),
        .wr_c0    (wr_c0),
        .wr_c1    (wr_c1),
        .wr_route (wr_route),
        .rd_skip  (rd_skip),
        .rd_slen  (rd_slen),
        .rd_c0    (rd_c0),
        .rd_c1    (rd_c1),
        .rd_route (rd_route)
    );

    assign route_in_ext = {16'b0, route_in};
    assign best_ext     = {{(32 - ROUTE_BITS - 1){1'b0}}, best_reg};
    assign used_ext     = {1'b0, used_reg};
    assign used_p1      = PTR_W'(used_reg + PTR_W'(1));
    assign used_p2      = PTR_W'(used_reg + PTR_W'(2));
    assign rest_len     = 7'(len_reg - pos_reg - 8'd1);
    // Branch bit at the prefix's last position, taken from the unshifted key.
    assign tail_bit     = key_orig_reg[7'(8'd128 - len_reg)];

    always_comb
    begin
        state_next       = state_reg;
        cmd_next         = cmd_reg;
        len_next         = len_reg;
        route_next       = route_reg;
        pos_next         = pos_reg;
        match_next       = match_reg;
        ptr_next         = ptr_reg;
        slen_next        = slen_reg;
        c0_next          = c0_reg;
        c1_next          = c1_reg;
        nroute_next      = nroute_reg;
        orig_skip_next   = orig_skip_reg;
        key_orig_next    = key_orig_reg;
        root_next        = root_reg;
        used_next        = used_reg;
        slot_root_next   = slot_root_reg;
        parent_next      = parent_reg;
        parent_bit_next  = parent_bit_reg;
        after_split_next = after_split_reg;
        link_next        = link_reg;
        best_next        = best_reg;
        fail_next        = fail_reg;
        done_next        = 1'b0;
        route_out_next   = route_out_reg;
        hit_next         = hit_reg;
        status_next      = status_reg;
        sh_cmd           = '0;
        rd_en            = 1'b0;
        rd_addr          = IDX_W'(ptr_reg - PTR_W'(1));
        wr_en            = '0;
        wr_addr          = IDX_W'(used_reg);
        wr_skip          = '0;
        wr_slen          = '0;
        wr_c0            = '0;
        wr_c1            = '0;
        wr_route         = '0;
        need             = 2'd0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    sh_cmd.load_key  = 1'b1;
                    cmd_next         = command;
                    key_orig_next    = {addr_high, addr_low};
                    route_next       = route_in_ext[ROUTE_BITS-1:0];
                    if (command == lpm_pkg::CMD_INSERT)
                    begin
                        len_next = (length > ADDR_LEN) ? ADDR_LEN : length;
                    end
                    else
                    begin
                        len_next = (length == IPV4_LEN) ? IPV4_LEN : ADDR_LEN;
                    end
                    pos_next         = '0;
                    ptr_next         = root_reg;
                    slot_root_next   = 1'b1;
                    after_split_next = 1'b0;
                    best_next        = '0;
                    fail_next        = 1'b0;
                    state_next       = S_PTR;
                end
            end

            S_PTR:
            begin
                if (ptr_reg != '0 && {1'b0, ptr_reg} <= POOL_SIZE)
                begin
                    rd_en      = 1'b1;
                    match_next = '0;
                    state_next = S_LOAD;
                end
                else if (cmd_reg == lpm_pkg::CMD_LOOKUP)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    need = (pos_reg == len_reg) ? 2'd1 : 2'd2;
                    if (used_ext + (PTR_W + 1)'(need) > POOL_SIZE)
                    begin
                        fail_next  = 1'b1;
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_TAIL;
                    end
                end
            end

            S_LOAD:
            begin
                sh_cmd.load_skip = 1'b1;
                orig_skip_next   = rd_skip;
                slen_next        = rd_slen;
                c0_next          = rd_c0;
                c1_next          = rd_c1;
                nroute_next      = rd_route;
                state_next       = S_CMP;
            end

            S_CMP:
            begin
                if (match_reg == slen_reg)
                begin
                    if (cmd_reg == lpm_pkg::CMD_LOOKUP)
                    begin
                        if (nroute_reg[ROUTE_BITS])
                        begin
                            best_next = nroute_reg;
                        end
                        if (pos_reg >= len_reg)
                        begin
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            ptr_next         = sh_bit ? c1_reg : c0_reg;
                            sh_cmd.shift_key = 1'b1;
                            pos_next         = pos_reg + 8'd1;
                            state_next       = S_PTR;
                        end
                    end
                    else if (pos_reg == len_reg)
                    begin
                        wr_en.route = 1'b1;
                        wr_addr     = IDX_W'(ptr_reg - PTR_W'(1));
                        wr_route    = {1'b1, route_reg};
                        state_next  = S_FINISH;
                    end
                    else
                    begin
                        parent_next      = ptr_reg;
                        parent_bit_next  = sh_bit;
                        slot_root_next   = 1'b0;
                        ptr_next         = sh_bit ? c1_reg : c0_reg;
                        sh_cmd.shift_key = 1'b1;
                        pos_next         = pos_reg + 8'd1;
                        state_next       = S_PTR;
                    end
                end
                else if (pos_reg >= len_reg || sh_mism)
                begin
                    if (cmd_reg == lpm_pkg::CMD_LOOKUP)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        if (pos_reg == len_reg)
                        begin
                            need = 2'd1;
                        end
                        else if (pos_reg + 8'd1 == len_reg)
                        begin
                            need = 2'd2;
                        end
                        else
                        begin
                            need = 2'd3;
                        end
                        if (used_ext + (PTR_W + 1)'(need) > POOL_SIZE)
                        begin
                            fail_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                        else
                        begin
                            state_next = S_SPLIT_INTER;
                        end
                    end
                end
                else
                begin
                    sh_cmd.shift_key  = 1'b1;
                    sh_cmd.shift_skip = 1'b1;
                    pos_next          = pos_reg + 8'd1;
                    match_next        = match_reg + 7'd1;
                end
            end

            S_SPLIT_INTER:
            begin
                // The new upper node keeps the matched part of the old skip and
                // points back to the old node on the old node's next bit.
                wr_en    = '{skip: 1'b1, c0: 1'b1, c1: 1'b1, route: 1'b1};
                wr_skip  = lpm_pkg::keep_top(orig_skip_reg, {1'b0, match_reg});
                wr_slen  = match_reg;
                wr_route = (pos_reg == len_reg) ? {1'b1, route_reg} : '0;
                if (sh_skip[KB-1])
                begin
                    wr_c1 = ptr_reg;
                    wr_c0 = (pos_reg == len_reg) ? '0 : used_p2;
                end
                else
                begin
                    wr_c0 = ptr_reg;
                    wr_c1 = (pos_reg == len_reg) ? '0 : used_p2;
                end
                link_next  = used_p1;
                used_next  = used_p1;
                state_next = S_SPLIT_NODE;
            end

            S_SPLIT_NODE:
            begin
                wr_en.skip = 1'b1;
                wr_addr    = IDX_W'(ptr_reg - PTR_W'(1));
                wr_slen    = 7'(slen_reg - match_reg - 7'd1);
                wr_skip    = lpm_pkg::keep_top({sh_skip[KB-2:0], 1'b0},
                                               {1'b0, 7'(slen_reg - match_reg - 7'd1)});
                if (pos_reg == len_reg)
                begin
                    state_next = S_LINK;
                end
                else
                begin
                    sh_cmd.shift_key = 1'b1;
                    pos_next         = pos_reg + 8'd1;
                    after_split_next = 1'b1;
                    state_next       = S_TAIL;
                end
            end

            S_TAIL:
            begin
                wr_en = '{skip: 1'b1, c0: 1'b1, c1: 1'b1, route: 1'b1};
                if (!after_split_reg)
                begin
                    link_next = used_p1;
                end
                used_next = used_p1;
                if (pos_reg == len_reg)
                begin
                    wr_route   = {1'b1, route_reg};
                    state_next = S_LINK;
                end
                else
                begin
                    wr_skip    = lpm_pkg::keep_top(sh_key, {1'b0, rest_len});
                    wr_slen    = rest_len;
                    wr_c0      = tail_bit ? '0 : used_p2;
                    wr_c1      = tail_bit ? used_p2 : '0;
                    state_next = S_TAIL_LEAF;
                end
            end

            S_TAIL_LEAF:
            begin
                wr_en      = '{skip: 1'b1, c0: 1'b1, c1: 1'b1, route: 1'b1};
                wr_route   = {1'b1, route_reg};
                used_next  = used_p1;
                state_next = S_LINK;
            end

            S_LINK:
            begin
                if (slot_root_reg)
                begin
                    root_next = link_reg;
                end
                else
                begin
                    wr_addr  = IDX_W'(parent_reg - PTR_W'(1));
                    wr_en.c0 = !parent_bit_reg;
                    wr_en.c1 = parent_bit_reg;
                    wr_c0    = link_reg;
                    wr_c1    = link_reg;
                end
                state_next = S_FINISH;
            end

            S_FINISH:
            begin
                done_next = 1'b1;
                if (cmd_reg == lpm_pkg::CMD_LOOKUP && best_reg[ROUTE_BITS])
                begin
                    route_out_next = 16'(best_ext & ((32'd1 << ROUTE_BITS) - 32'd1));
                    hit_next       = 1'b1;
                end
                else
                begin
                    route_out_next = '0;
                    hit_next       = 1'b0;
                end
                status_next = fail_reg;
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            root_reg        <= '0;
            used_reg        <= '0;
            done_reg        <= 1'b0;
            route_out_reg   <= '0;
            hit_reg         <= 1'b0;
            status_reg      <= 1'b0;
            cmd_reg         <= 1'b0;
            slot_root_reg   <= 1'b1;
            after_split_reg <= 1'b0;
            fail_reg        <= 1'b0;
            best_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            root_reg        <= root_next;
            used_reg        <= used_next;
            done_reg        <= done_next;
            route_out_reg   <= route_out_next;
            hit_reg         <= hit_next;
            status_reg      <= status_next;
            cmd_reg         <= cmd_next;
            slot_root_reg   <= slot_root_next;
            after_split_reg <= after_split_next;
            fail_reg        <= fail_next;
            best_reg        <= best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        len_reg        <= len_next;
        route_reg      <= route_next;
        pos_reg        <= pos_next;
        match_reg      <= match_next;
        ptr_reg        <= ptr_next;
        slen_reg       <= slen_next;
        c0_reg         <= c0_next;
        c1_reg         <= c1_next;
        nroute_reg     <= nroute_next;
        orig_skip_reg  <= orig_skip_next;
        key_orig_reg   <= key_orig_next;
        parent_reg     <= parent_next;
        parent_bit_reg <= parent_bit_next;
        link_reg       <= link_next;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign route_out = route_out_reg;
    assign hit       = hit_reg;
    assign status    = status_reg;

    `LPM_ASSERT_IMP(a_pool_bound, 1'b1, {1'b0, used_reg} <= POOL_SIZE, "node pool overrun")
    `LPM_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted transaction did not start")
    `LPM_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while still busy")
    `LPM_ASSERT_IMP(a_hit_status, done && hit, !status, "hit together with pool-full status")

endmodule

`default_nettype wire
